// File: hw/rtl/dmpd_pkg.sv
// Shared types and constants for the dual motor incremental PD speed unit.
// No dependencies; every other file imports this package.
package dmpd_pkg;

   localparam int SPEED_W   = 16;
   localparam int GAIN_W    = 10;
   localparam int DUTY_W    = 15;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 15;

   localparam logic [GAIN_W-1:0] KP_GAIN_RESET    = 10'd77;
   localparam logic [GAIN_W-1:0] KD_GAIN_RESET    = 10'd205;
   localparam logic [DUTY_W-1:0] DUTY_LIMIT_RESET = 15'd200;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP_GAIN    = 2'd0,
      CSR_KD_GAIN    = 2'd1,
      CSR_DUTY_LIMIT = 2'd2
   } csr_index_type;

   // Per-side result of one control tick
   typedef struct packed {
      logic [DUTY_W-1:0]         duty;
      logic                      reverse;
      logic signed [SPEED_W-1:0] err;
   } side_result_type;

endpackage

// File: hw/rtl/dmpd_channels.sv
// Valid/ready channel interfaces for the speed unit: request and response.
// Depends on dmpd_pkg for field widths.
interface dmpd_req_if
   import dmpd_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] set_left;
   logic signed [SPEED_W-1:0] set_right;
   logic signed [SPEED_W-1:0] count_left;
   logic signed [SPEED_W-1:0] count_right;

   modport source (output valid, set_left, set_right, count_left, count_right,
                   input ready);
   modport sink   (input valid, set_left, set_right, count_left, count_right,
                   output ready);
endinterface

interface dmpd_rsp_if
   import dmpd_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty_left;
   logic              reverse_left;
   logic [DUTY_W-1:0] duty_right;
   logic              reverse_right;

   modport source (output valid, duty_left, reverse_left, duty_right, reverse_right,
                   input ready);
   modport sink   (input valid, duty_left, reverse_left, duty_right, reverse_right,
                   output ready);
endinterface

// File: hw/rtl/dual_motor_incremental_pd_speed_unit.sv
// Top level of the dual motor incremental PD speed unit.
// Depends on dmpd_pkg and the channel interfaces in dmpd_channels.sv.
//
// Usage:
//   req carries one control tick: signed set speeds and encoder counts for
//   the left and right motor. rsp returns one beat per tick: the clamped duty
//   and the direction bit of each side. Both are valid/ready channels; a beat
//   moves on a clock edge with valid and ready high.
//   csr_wr_en/csr_index/csr_wdata write the gains (kp, kd, Q2.8) and the duty
//   limit; write them only while no tick is in flight.
//   An accepted beat passes the input register, then the output register,
//   to rsp. Throughput: one beat per cycle while rsp is taken; the whole PD
//   update is one registered pass from the input register to the output
//   register, with the kept duty and error updated on that pass.
//   Reset: synchronous, active high; clears both stages, the kept duties and
//   previous errors, and loads the default gains and limit.
//   Stall: while rsp is not taken the output holds; one more request beat
//   is absorbed in the input register, then req.ready drops.
module dual_motor_incremental_pd_speed_unit
   import dmpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   dmpd_req_if.sink             req,
   dmpd_rsp_if.source           rsp,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   // configuration
   logic [GAIN_W-1:0] kp_gain_ff;
   logic [GAIN_W-1:0] kd_gain_ff;
   logic [DUTY_W-1:0] duty_limit_ff;

   // input stage
   logic                      a_vld_ff;
   logic signed [SPEED_W-1:0] a_set_left_ff, a_set_right_ff;
   logic signed [SPEED_W-1:0] a_cnt_left_ff, a_cnt_right_ff;

   // per-side state
   logic signed [SPEED_W-1:0] prev_err_left_ff, prev_err_right_ff;
   logic [DUTY_W-1:0]         duty_acc_left_ff, duty_acc_right_ff;

   // output stage
   logic              out_vld_ff;
   logic [DUTY_W-1:0] out_duty_left_ff, out_duty_right_ff;
   logic              out_rev_left_ff, out_rev_right_ff;

   logic            accept;
   logic            advance;
   side_result_type left_in, right_in;

   function automatic side_result_type run_side(
      input logic signed [SPEED_W-1:0] set_v,
      input logic signed [SPEED_W-1:0] cnt_v,
      input logic signed [SPEED_W-1:0] prev_err,
      input logic [DUTY_W-1:0]         duty_acc,
      input logic [GAIN_W-1:0]         kp,
      input logic [GAIN_W-1:0]         kd,
      input logic [DUTY_W-1:0]         limit
   );
      logic                      rev;
      logic signed [SPEED_W:0]   set_w;
      logic signed [SPEED_W:0]   cnt_w;
      logic signed [SPEED_W+1:0] diff;
      logic signed [SPEED_W-1:0] err;
      logic signed [SPEED_W:0]   derr;
      logic signed [GAIN_W:0]    kp_s;
      logic signed [GAIN_W:0]    kd_s;
      logic signed [27:0]        p_term;
      logic signed [27:0]        d_term;
      logic signed [27:0]        sum;
      logic signed [27:0]        sum_adj;
      logic signed [19:0]        inc;
      logic signed [20:0]        total;
      side_result_type           res;
      rev   = set_v[SPEED_W-1];
      set_w = {set_v[SPEED_W-1], set_v};
      cnt_w = {cnt_v[SPEED_W-1], cnt_v};
      if (rev) begin
         set_w = -set_w;
         cnt_w = -cnt_w;
      end
      diff = {set_w[SPEED_W], set_w} - {cnt_w[SPEED_W], cnt_w};
      if (diff > 18'sd32767) begin
         err = 16'sh7FFF;
      end else if (diff < -18'sd32768) begin
         err = 16'sh8000;
      end else begin
         err = diff[SPEED_W-1:0];
      end
      derr   = {err[SPEED_W-1], err} - {prev_err[SPEED_W-1], prev_err};
      kp_s   = {1'b0, kp};
      kd_s   = {1'b0, kd};
      p_term = 28'(kp_s) * 28'(err);
      d_term = 28'(kd_s) * 28'(derr);
      sum    = p_term + d_term;
      // truncate toward zero: bias negatives before the arithmetic shift
      sum_adj = sum[27] ? sum + 28'sd255 : sum;
      inc     = 20'(sum_adj >>> 8);
      total   = $signed({6'b0, duty_acc}) + 21'(inc);
      if (total < 21'sd0) begin
         res.duty = '0;
      end else if (total > $signed({6'b0, limit})) begin
         res.duty = limit;
      end else begin
         res.duty = total[DUTY_W-1:0];
      end
      res.reverse = rev;
      res.err     = err;
      return res;
   endfunction

   assign advance   = a_vld_ff && (!out_vld_ff || rsp.ready);
   assign req.ready = !a_vld_ff || advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      left_in  = run_side(a_set_left_ff, a_cnt_left_ff, prev_err_left_ff,
                          duty_acc_left_ff, kp_gain_ff, kd_gain_ff, duty_limit_ff);
      right_in = run_side(a_set_right_ff, a_cnt_right_ff, prev_err_right_ff,
                          duty_acc_right_ff, kp_gain_ff, kd_gain_ff, duty_limit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_gain_ff    <= KP_GAIN_RESET;
         kd_gain_ff    <= KD_GAIN_RESET;
         duty_limit_ff <= DUTY_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KP_GAIN:    kp_gain_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_KD_GAIN:    kd_gain_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_DUTY_LIMIT: duty_limit_ff <= csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (req.ready) begin
         a_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_set_left_ff  <= req.set_left;
         a_set_right_ff <= req.set_right;
         a_cnt_left_ff  <= req.count_left;
         a_cnt_right_ff <= req.count_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_left_ff  <= '0;
         prev_err_right_ff <= '0;
         duty_acc_left_ff  <= '0;
         duty_acc_right_ff <= '0;
      end else if (advance) begin
         prev_err_left_ff  <= left_in.err;
         prev_err_right_ff <= right_in.err;
         duty_acc_left_ff  <= left_in.duty;
         duty_acc_right_ff <= right_in.duty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_duty_left_ff  <= left_in.duty;
         out_rev_left_ff   <= left_in.reverse;
         out_duty_right_ff <= right_in.duty;
         out_rev_right_ff  <= right_in.reverse;
      end
   end

   assign rsp.valid         = out_vld_ff;
   assign rsp.duty_left     = out_duty_left_ff;
   assign rsp.reverse_left  = out_rev_left_ff;
   assign rsp.duty_right    = out_duty_right_ff;
   assign rsp.reverse_right = out_rev_right_ff;

endmodule

// File: hw/rtl/dmpd_checker.sv
// Port-level assertions for the speed unit, attached by bind.
// Depends on dmpd_pkg and dual_motor_incremental_pd_speed_unit.
module dmpd_checker
   import dmpd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DUTY_W-1:0] duty_left,
   input logic              reverse_left,
   input logic [DUTY_W-1:0] duty_right,
   input logic              reverse_right
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // an accepted beat reaches the output through the input and output registers
   a_beat_delivered: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ##1 rsp_valid)
      else $error("accepted beat not delivered in time");

   // an empty output stage never blocks the request side
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(duty_left)
         && $stable(reverse_left) && $stable(duty_right) && $stable(reverse_right))
      else $error("stalled rsp beat changed");

endmodule

bind dual_motor_incremental_pd_speed_unit dmpd_checker u_dmpd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .duty_left     (rsp.duty_left),
   .reverse_left  (rsp.reverse_left),
   .duty_right    (rsp.duty_right),
   .reverse_right (rsp.reverse_right)
);
